// ===== rtl/core/mii_pkg.sv =====
// Shared types, constants and helpers for the masked integral image block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mii_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int PIXEL_BITS_DEF = 16;

	localparam int SUM_W     = 36;
	localparam int SIZE_W    = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASK_ENABLE  = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic              mask_en;
		logic [SIZE_W-1:0] width_last;
		logic [SIZE_W-1:0] height_last;
	} cfg_t;

	typedef struct packed {
		logic first_row;
		logic row_end;
		logic frame_end;
	} pos_flags_t;

	// Last valid position for a configured size: zero acts as one and the
	// size saturates at the synthesised maximum.
	function automatic logic [SIZE_W-1:0] clamp_last(input logic [SIZE_W-1:0] v,
		input int max_size);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (int'(v) > max_size) begin
			r = SIZE_W'(max_size - 1);
		end else begin
			r = v - 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/mii_if.sv =====
// Handshake interfaces for the pixel input, result output and configuration write channels.
// Depends on mii_pkg for the field widths.
`timescale 1ns / 1ps

interface mii_pix_if #(parameter int PIXEL_BITS = 16) ();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;
	logic                  pixel_valid;

	modport source (output valid, pixel, pixel_valid, input ready);
	modport sink (input valid, pixel, pixel_valid, output ready);
endinterface

interface mii_res_if import mii_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] integral;
	logic             row_end;
	logic             frame_end;

	modport source (output valid, integral, row_end, frame_end, input ready);
	modport sink (input valid, integral, row_end, frame_end, output ready);
endinterface

interface mii_cfg_if import mii_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SIZE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mii_cfg.sv =====
// Configuration registers: mask enable and frame size, with the size clamping.
// Depends on mii_pkg and the mii_cfg_if interface.
`timescale 1ns / 1ps

module mii_cfg import mii_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mii_cfg_if.sink   cfg,
	output cfg_t      ctrl
);

	logic              mask_en_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_en_q <= 1'b0;
			width_q   <= SIZE_RESET;
			height_q  <= SIZE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MASK_ENABLE:  mask_en_q <= cfg.data[0];
				REG_IMAGE_WIDTH:  width_q   <= cfg.data;
				REG_IMAGE_HEIGHT: height_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ctrl.mask_en     = mask_en_q;
		ctrl.width_last  = clamp_last(width_q, MAX_WIDTH);
		ctrl.height_last = clamp_last(height_q, MAX_HEIGHT);
	end

endmodule

// ===== rtl/core/mii_line_buf.sv =====
// Line store holding the previous row's integral values, one entry per column.
// Single write port and one registered read port; depends on mii_pkg for defaults.
`timescale 1ns / 1ps

module mii_line_buf import mii_pkg::*; #(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int WIDTH = SUM_W
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/mii_front.sv =====
// Input stage: column and row counters, masked running row sum and the first pipeline register.
// Depends on mii_pkg.
`timescale 1ns / 1ps

module mii_front import mii_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	localparam int COL_W  = $clog2(MAX_WIDTH),
	localparam int RSUM_W = (PIXEL_BITS + COL_W < SUM_W) ? PIXEL_BITS + COL_W : SUM_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  ctrl,
	input  logic                  accept,
	input  logic [PIXEL_BITS-1:0] pixel,
	input  logic                  pixel_valid,
	output logic [COL_W-1:0]      col,
	output logic [COL_W-1:0]      col_s1,
	output logic [RSUM_W-1:0]     rsum_s1,
	output pos_flags_t            flags_s1
);

	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int CCMP_W = (COL_W > SIZE_W) ? COL_W : SIZE_W;
	localparam int RCMP_W = (ROW_W > SIZE_W) ? ROW_W : SIZE_W;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [RSUM_W-1:0] rsum_q;
	logic [RSUM_W-1:0] rsum_next;
	logic              counts;
	logic              last_col;
	logic              last_row;

	assign col = col_q;

	always_comb begin
		counts    = !ctrl.mask_en || pixel_valid;
		rsum_next = rsum_q + (counts ? RSUM_W'(pixel) : '0);
		last_col  = CCMP_W'(col_q) >= CCMP_W'(ctrl.width_last);
		last_row  = RCMP_W'(row_q) >= RCMP_W'(ctrl.height_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			rsum_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q  <= '0;
				rsum_q <= '0;
				row_q  <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q  <= col_q + 1'b1;
				rsum_q <= rsum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1             <= col_q;
			rsum_s1            <= rsum_next;
			flags_s1.first_row <= row_q == '0;
			flags_s1.row_end   <= last_col;
			flags_s1.frame_end <= last_col && last_row;
		end
	end

endmodule

// ===== rtl/core/masked_integral_image.sv =====
// Masked integral image: streams pixels in raster order, one summed-area value per pixel.
// A result is offered once its pixel has passed the input register and then the result register.
// Throughput: one pixel per cycle unless results stall; 1-read 1-write line store with forwarding.
// Reset clears the counters, row sum, configuration and valid flags; the line store is not cleared,
// since the first row of each frame never reads it.
// Depends on mii_pkg, the interfaces in mii_if, mii_cfg, mii_front and mii_line_buf.
`timescale 1ns / 1ps

module masked_integral_image import mii_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mii_pix_if.sink    pix,
	mii_res_if.source  res,
	mii_cfg_if.sink    cfg
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int RSUM_W = (PIXEL_BITS + COL_W < SUM_W) ? PIXEL_BITS + COL_W : SUM_W;

	cfg_t              ctrl;
	logic              accept;
	logic              adv;
	logic              s1_valid_q;
	logic              out_valid_q;
	logic [COL_W-1:0]  col;
	logic [COL_W-1:0]  col_s1;
	logic [RSUM_W-1:0] rsum_s1;
	pos_flags_t        flags_s1;
	logic [SUM_W-1:0]  rd_data;
	logic [SUM_W-1:0]  byp_s1;
	logic              byp_sel_s1;
	logic [SUM_W-1:0]  above;
	logic [SUM_W-1:0]  total;
	logic [SUM_W-1:0]  integral_q;
	logic              row_end_q;
	logic              frame_end_q;

	mii_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ctrl   (ctrl)
	);

	mii_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.accept      (accept),
		.pixel       (pix.pixel),
		.pixel_valid (pix.pixel_valid),
		.col         (col),
		.col_s1      (col_s1),
		.rsum_s1     (rsum_s1),
		.flags_s1    (flags_s1)
	);

	mii_line_buf #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (SUM_W)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.rd_data (rd_data),
		.wr_en   (adv),
		.wr_addr (col_s1),
		.wr_data (total)
	);

	assign adv       = s1_valid_q && (!out_valid_q || res.ready);
	assign pix.ready = !s1_valid_q || adv;
	assign accept    = pix.valid && pix.ready;

	always_comb begin
		if (flags_s1.first_row) begin
			above = '0;
		end else if (byp_sel_s1) begin
			above = byp_s1;
		end else begin
			above = rd_data;
		end
		total = SUM_W'(rsum_s1) + above;
	end

	// A store write in the same cycle as a read of the same column is forwarded.
	always_ff @(posedge clk) begin
		if (accept) begin
			byp_sel_s1 <= adv && (col_s1 == col);
			byp_s1     <= total;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pix.ready) begin
				s1_valid_q <= pix.valid;
			end
			if (!out_valid_q || res.ready) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			integral_q  <= total;
			row_end_q   <= flags_s1.row_end;
			frame_end_q <= flags_s1.frame_end;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.integral  = integral_q;
	assign res.row_end   = row_end_q;
	assign res.frame_end = frame_end_q;

endmodule

// ===== sim/tb_masked_integral_image.sv =====
// Testbench for masked_integral_image: streams pixel items with random idling on both sides
// and checks every result item against a summed-area predictor kept in a small scoreboard.
// Depends on mii_pkg, the interfaces in mii_if and the block's RTL.
`timescale 1ns / 1ps

module tb_masked_integral_image;
	import mii_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1850;

	typedef struct packed {
		logic [SUM_W-1:0] integral;
		logic             row_end;
		logic             frame_end;
	} sat_entry_t;

	class area_sum_tracker;
		bit                mask_on    = 1'b0;
		logic [SIZE_W-1:0] width_reg  = SIZE_RESET;
		logic [SIZE_W-1:0] height_reg = SIZE_RESET;
		logic [SUM_W-1:0]  line_store [MAX_WIDTH_DEF];
		logic [SUM_W-1:0]  run_sum    = '0;
		int unsigned       col        = 0;
		int unsigned       row        = 0;
		sat_entry_t        due_sums [$];
		int unsigned       mismatches = 0;

		function int unsigned span(logic [SIZE_W-1:0] v, int unsigned limit);
			if (v == '0) return 1;
			if (int'(v) > limit) return limit;
			return v;
		endfunction

		function bit in_first_row();
			return row == 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] v);
			case (idx)
				REG_MASK_ENABLE:  mask_on = v[0];
				REG_IMAGE_WIDTH:  width_reg = v;
				REG_IMAGE_HEIGHT: height_reg = v;
				default: ;
			endcase
		endfunction

		function void take_pixel(logic [PIXEL_BITS_DEF-1:0] pixel, logic counted);
			int unsigned      w;
			int unsigned      h;
			logic [SUM_W-1:0] above;
			sat_entry_t       e;
			w = span(width_reg, MAX_WIDTH_DEF);
			h = span(height_reg, MAX_HEIGHT_DEF);
			if (col == 0) run_sum = '0;
			if (!mask_on || counted) run_sum = run_sum + SUM_W'(pixel);
			above = (row != 0) ? line_store[col] : '0;
			e.integral = run_sum + above;
			line_store[col] = e.integral;
			e.row_end = (col >= w - 1);
			e.frame_end = e.row_end && (row >= h - 1);
			due_sums.push_back(e);
			if (e.row_end) begin
				col = 0;
				row = e.frame_end ? 0 : row + 1;
			end else begin
				col++;
			end
		endfunction

		function void match_result(logic [SUM_W-1:0] integral, logic row_end, logic frame_end);
			sat_entry_t e;
			if (due_sums.size() == 0) begin
				$error("unexpected result item: integral %0d", integral);
				mismatches++;
				return;
			end
			e = due_sums.pop_front();
			if (integral !== e.integral) begin
				$error("integral: expected %0d, actual %0d", e.integral, integral);
				mismatches++;
			end
			if (row_end !== e.row_end) begin
				$error("row_end: expected %0b, actual %0b", e.row_end, row_end);
				mismatches++;
			end
			if (frame_end !== e.frame_end) begin
				$error("frame_end: expected %0b, actual %0b", e.frame_end, frame_end);
				mismatches++;
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n;
	bit              calm = 1'b0;
	area_sum_tracker tracker = new();

	mii_pix_if #(.PIXEL_BITS(PIXEL_BITS_DEF)) pix_if ();
	mii_res_if res_if ();
	mii_cfg_if cfg_if ();

	masked_integral_image u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		res_if.ready <= calm || ($urandom_range(99) >= 37);
	end

	always @(posedge clk) begin
		if (res_if.valid && res_if.ready) begin
			tracker.match_result(res_if.integral, res_if.row_end, res_if.frame_end);
		end
	end

	function automatic logic [PIXEL_BITS_DEF-1:0] rand_pixel();
		case ($urandom_range(6))
			0: return '0;
			1: return '1;
			default: return PIXEL_BITS_DEF'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [PIXEL_BITS_DEF-1:0] value, input logic counted);
		while (!calm && $urandom_range(99) < 37) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid       <= 1'b1;
		pix_if.pixel       <= value;
		pix_if.pixel_valid <= counted;
		do @(posedge clk); while (!pix_if.ready);
		tracker.take_pixel(value, counted);
	endtask

	task automatic drain();
		pix_if.valid <= 1'b0;
		while (tracker.due_sums.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		tracker.set_reg(idx, value);
	endtask

	task automatic configure(input logic mask, input logic [SIZE_W-1:0] w,
		input logic [SIZE_W-1:0] h);
		drain();
		// Widening outside the first row would make the next rows read line-store
		// entries that the previous row never wrote, so the width is kept instead.
		if (!tracker.in_first_row() && tracker.span(w, MAX_WIDTH_DEF) >
			tracker.span(tracker.width_reg, MAX_WIDTH_DEF)) begin
			w = tracker.width_reg;
		end
		write_reg(REG_MASK_ENABLE, SIZE_W'(mask));
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		int unsigned       count;
		int unsigned       random_sent;
		logic [SIZE_W-1:0] w_reg;
		logic [SIZE_W-1:0] h_reg;

		arst_n             <= 1'b0;
		pix_if.valid       <= 1'b0;
		pix_if.pixel       <= '0;
		pix_if.pixel_valid <= 1'b0;
		cfg_if.valid       <= 1'b0;
		cfg_if.index       <= '0;
		cfg_if.data        <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// At the reset sizes these items all fall in the first row of a wide frame.
		send_pixel(16'h0000, 1'b1);
		send_pixel(16'hFFFF, 1'b1);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0001, 1'b0);
		send_pixel(16'h8000, 1'b1);
		send_pixel(16'h5555, 1'b0);

		// A write to an unused index is ignored; masking then zeroes unflagged pixels.
		drain();
		write_reg(REG_UNUSED, '1);
		write_reg(REG_MASK_ENABLE, SIZE_W'(1));
		cfg_if.valid <= 1'b0;
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'hFFFF, 1'b1);
		send_pixel(16'hAAAA, 1'b0);

		// Zero sizes act as one, and shrinking in mid-row ends the row at once.
		configure(1'b1, '0, '0);
		repeat (3) send_pixel(16'hFFFF, 1'b1);
		configure(1'b0, SIZE_W'(2), SIZE_W'(3));
		repeat (6) send_pixel(16'hFFFF, 1'b0);

		// One long stretch without idling across a saturated full-width row.
		calm = 1'b1;
		configure(1'($urandom), SIZE_W'($urandom_range(1024, 2047)), SIZE_W'(2));
		count = MAX_WIDTH_DEF + $urandom_range(20, 80);
		repeat (count) send_pixel(rand_pixel(), 1'($urandom));
		random_sent = count;

		while (random_sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(4) == 0);
			case ($urandom_range(9))
				0: w_reg = '0;
				1: w_reg = SIZE_W'($urandom_range(17, 80));
				2: w_reg = SIZE_W'($urandom_range(1025, 2047));
				default: w_reg = SIZE_W'($urandom_range(1, 16));
			endcase
			case ($urandom_range(9))
				0: h_reg = '0;
				1: h_reg = SIZE_W'($urandom_range(7, 2047));
				default: h_reg = SIZE_W'($urandom_range(1, 6));
			endcase
			configure(1'($urandom), w_reg, h_reg);
			count = tracker.span(tracker.width_reg, MAX_WIDTH_DEF) *
				tracker.span(tracker.height_reg, MAX_HEIGHT_DEF) * $urandom_range(1, 3);
			if ($urandom_range(3) == 0) count += $urandom_range(1, 20);
			if (count > 250) count = $urandom_range(100, 250);
			repeat (count) send_pixel(rand_pixel(), 1'($urandom));
			random_sent += count;
		end

		drain();
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.due_sums.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
